// File: sv/qrs_pkg.sv
// Shared constants, types and codes of the quadratic real-root solver.
package qrs_pkg;

  // Coefficient format: signed, eight fraction bits.
  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int ROOT_BITS = 32;

  // Discriminant and square-root widths.
  localparam int D_BITS    = 2 * COEF_BITS + 2;
  localparam int RAD_BITS  = D_BITS + 2 * FRAC_BITS;
  localparam int SQ_BITS   = RAD_BITS / 2;
  localparam int NB_BITS   = COEF_BITS + FRAC_BITS + 1;
  localparam int SUM_BITS  = SQ_BITS + 2;

  // Divider widths.
  localparam int NUM_BITS  = SUM_BITS - 1 + FRAC_BITS;
  localparam int DEN_BITS  = COEF_BITS + 1;
  localparam int REM_BITS  = DEN_BITS + 1;
  localparam int QUO_BITS  = NUM_BITS;
  localparam int LANES     = 2;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [ROOT_BITS-1:0] root_t;

  typedef enum logic [2:0] {
    KIND_NOT_EQ  = 3'd0,
    KIND_NO_ROOT = 3'd1,
    KIND_LINEAR  = 3'd2,
    KIND_DOUBLE  = 3'd3,
    KIND_TWO     = 3'd4
  } kind_e;

  // Side information carried alongside the square-root pipeline.
  typedef struct packed {
    kind_e                     kind;
    logic signed [NB_BITS-1:0] nb;
    coef_t                     a;
    coef_t                     b;
    coef_t                     c;
  } sq_side_t;

  // Side information carried alongside the divider pipeline.
  typedef struct packed {
    kind_e kind;
    logic  neg1;
    logic  neg2;
  } dv_side_t;

  // One finished result.
  typedef struct packed {
    kind_e kind;
    root_t r1;
    root_t r2;
    logic  sat;
  } res_t;

endpackage

// File: sv/qrs_if.sv
// Valid/ready channel interfaces for coefficients in and roots out.
interface qrs_coef_if;
  import qrs_pkg::*;
  logic  valid;
  logic  ready;
  coef_t coef_a;
  coef_t coef_b;
  coef_t coef_c;
  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if;
  import qrs_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] root_kind;
  root_t      root_one;
  root_t      root_two;
  logic       saturated;
  modport source (output valid, output root_kind, output root_one, output root_two,
                  output saturated, input ready);
  modport sink (input valid, input root_kind, input root_one, input root_two,
                input saturated, output ready);
endinterface

// File: sv/qrs_front.sv
// Front end: products, exact discriminant and classification in two stages.
module qrs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  qrs_pkg::coef_t               a_i,
  input  qrs_pkg::coef_t               b_i,
  input  qrs_pkg::coef_t               c_i,
  output logic                         valid_o,
  output logic [qrs_pkg::RAD_BITS-1:0] rad_o,
  output qrs_pkg::sq_side_t            side_o
);
  import qrs_pkg::*;

  logic                   v1_q;
  coef_t                  a1_q, b1_q, c1_q;
  logic [2*COEF_BITS-1:0] bb1_q, ac1_q, bb1_d, ac1_d;
  logic [COEF_BITS-1:0]   ua, ub, uc;

  logic                   v2_q;
  logic [RAD_BITS-1:0]    rad2_q, rad2_d;
  sq_side_t               side2_q, side2_d;

  logic [D_BITS-1:0]      bb, ac4, d;
  logic                   ac_neg, d_neg;
  logic signed [NB_BITS-1:0] bx;

  // Magnitudes and the two unsigned products.
  always_comb begin
    ua    = a_i[COEF_BITS-1] ? COEF_BITS'(-a_i) : COEF_BITS'(a_i);
    ub    = b_i[COEF_BITS-1] ? COEF_BITS'(-b_i) : COEF_BITS'(b_i);
    uc    = c_i[COEF_BITS-1] ? COEF_BITS'(-c_i) : COEF_BITS'(c_i);
    bb1_d = (2*COEF_BITS)'(ub) * (2*COEF_BITS)'(ub);
    ac1_d = (2*COEF_BITS)'(ua) * (2*COEF_BITS)'(uc);
  end

  // Discriminant, its sign, and the kind of equation.
  always_comb begin
    bb     = D_BITS'(bb1_q);
    ac4    = {ac1_q, 2'b00};
    ac_neg = a1_q[COEF_BITS-1] ^ c1_q[COEF_BITS-1];
    d_neg  = 1'b0;
    if (c1_q == '0 || ac_neg) begin
      d = bb + ac4;
    end else if (bb >= ac4) begin
      d = bb - ac4;
    end else begin
      d     = bb;
      d_neg = 1'b1;
    end

    if (a1_q == '0 && b1_q == '0 && c1_q == '0) begin
      side2_d.kind = KIND_NOT_EQ;
    end else if (a1_q == '0) begin
      side2_d.kind = (b1_q == '0) ? KIND_NO_ROOT : KIND_LINEAR;
    end else if (d_neg) begin
      side2_d.kind = KIND_NO_ROOT;
    end else if (d == '0) begin
      side2_d.kind = KIND_DOUBLE;
    end else begin
      side2_d.kind = KIND_TWO;
    end

    bx         = NB_BITS'(b1_q);
    side2_d.nb = -(bx <<< FRAC_BITS);
    side2_d.a  = a1_q;
    side2_d.b  = b1_q;
    side2_d.c  = c1_q;
    rad2_d     = (side2_d.kind == KIND_TWO) ? {d, {(2*FRAC_BITS){1'b0}}} : '0;
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a_i;
      b1_q    <= b_i;
      c1_q    <= c_i;
      bb1_q   <= bb1_d;
      ac1_q   <= ac1_d;
      rad2_q  <= rad2_d;
      side2_q <= side2_d;
    end
  end

  assign valid_o = v2_q;
  assign rad_o   = rad2_q;
  assign side_o  = side2_q;

endmodule

// File: sv/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [qrs_pkg::RAD_BITS-1:0] rad_i,
  input  qrs_pkg::sq_side_t            side_i,
  output logic                         valid_o,
  output logic [qrs_pkg::SQ_BITS-1:0]  root_o,
  output qrs_pkg::sq_side_t            side_o
);
  import qrs_pkg::*;

  logic [SQ_BITS-1:0]  v_q;
  logic [RAD_BITS-1:0] rad_q  [SQ_BITS];
  logic [SUM_BITS-1:0] rem_q  [SQ_BITS];
  logic [SQ_BITS-1:0]  root_q [SQ_BITS];
  sq_side_t            side_q [SQ_BITS];

  logic [RAD_BITS-1:0] rad_d  [SQ_BITS];
  logic [SUM_BITS-1:0] rem_d  [SQ_BITS];
  logic [SQ_BITS-1:0]  root_d [SQ_BITS];

  // One digit step per stage: bring down two radicand bits and try a one.
  always_comb begin
    logic [RAD_BITS-1:0] s_rad;
    logic [SUM_BITS-1:0] s_rem, r2, tr;
    logic [SQ_BITS-1:0]  s_root;
    for (int k = 0; k < SQ_BITS; k++) begin
      if (k == 0) begin
        s_rad  = rad_i;
        s_rem  = '0;
        s_root = '0;
      end else begin
        s_rad  = rad_q[k-1];
        s_rem  = rem_q[k-1];
        s_root = root_q[k-1];
      end
      r2       = {s_rem[SQ_BITS-1:0], s_rad[RAD_BITS-1 -: 2]};
      tr       = {s_root, 2'b01};
      rad_d[k] = s_rad << 2;
      if (r2 >= tr) begin
        rem_d[k]  = r2 - tr;
        root_d[k] = {s_root[SQ_BITS-2:0], 1'b1};
      end else begin
        rem_d[k]  = r2;
        root_d[k] = {s_root[SQ_BITS-2:0], 1'b0};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[SQ_BITS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQ_BITS; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[SQ_BITS-1];
  assign root_o  = root_q[SQ_BITS-1];
  assign side_o  = side_q[SQ_BITS-1];

endmodule

// File: sv/qrs_div.sv
// Two-lane pipelined restoring divider of magnitudes, one quotient bit per stage.
module qrs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [qrs_pkg::NUM_BITS-1:0] num_i [qrs_pkg::LANES],
  input  logic [qrs_pkg::DEN_BITS-1:0] den_i [qrs_pkg::LANES],
  input  qrs_pkg::dv_side_t            side_i,
  output logic                         valid_o,
  output logic [qrs_pkg::QUO_BITS-1:0] quo_o [qrs_pkg::LANES],
  output qrs_pkg::dv_side_t            side_o
);
  import qrs_pkg::*;

  logic [QUO_BITS-1:0] v_q;
  logic [NUM_BITS-1:0] dvd_q [QUO_BITS][LANES];
  logic [REM_BITS-1:0] rem_q [QUO_BITS][LANES];
  logic [QUO_BITS-1:0] quo_q [QUO_BITS][LANES];
  logic [DEN_BITS-1:0] den_q [QUO_BITS][LANES];
  dv_side_t            side_q [QUO_BITS];

  logic [NUM_BITS-1:0] dvd_d [QUO_BITS][LANES];
  logic [REM_BITS-1:0] rem_d [QUO_BITS][LANES];
  logic [QUO_BITS-1:0] quo_d [QUO_BITS][LANES];
  logic [DEN_BITS-1:0] den_d [QUO_BITS][LANES];

  // Shift in the next dividend bit and subtract the divisor where it fits.
  always_comb begin
    logic [NUM_BITS-1:0] s_dvd;
    logic [REM_BITS-1:0] s_rem, r2, dx;
    logic [QUO_BITS-1:0] s_quo;
    logic [DEN_BITS-1:0] s_den;
    logic                ge;
    for (int k = 0; k < QUO_BITS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          s_dvd = num_i[l];
          s_rem = '0;
          s_quo = '0;
          s_den = den_i[l];
        end else begin
          s_dvd = dvd_q[k-1][l];
          s_rem = rem_q[k-1][l];
          s_quo = quo_q[k-1][l];
          s_den = den_q[k-1][l];
        end
        r2          = {s_rem[REM_BITS-2:0], s_dvd[NUM_BITS-1]};
        dx          = {1'b0, s_den};
        ge          = (r2 >= dx);
        rem_d[k][l] = ge ? (r2 - dx) : r2;
        quo_d[k][l] = {s_quo[QUO_BITS-2:0], ge};
        dvd_d[k][l] = s_dvd << 1;
        den_d[k][l] = s_den;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QUO_BITS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QUO_BITS; k++) begin
        for (int l = 0; l < LANES; l++) begin
          dvd_q[k][l] <= dvd_d[k][l];
          rem_q[k][l] <= rem_d[k][l];
          quo_q[k][l] <= quo_d[k][l];
          den_q[k][l] <= den_d[k][l];
        end
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[QUO_BITS-1];
  assign quo_o   = quo_q[QUO_BITS-1];
  assign side_o  = side_q[QUO_BITS-1];

endmodule

// File: sv/quadratic_real_root_solver_unit.sv
// Quadratic real-root solver: top level with numerator set-up, final clamp and output buffering.
// Takes one coefficient set (a, b, c, signed Q8.8) per cycle while the skid is empty and returns
// the equation kind and its real roots in Q16.16, clamped with a flag. A result passes through
// two front stages for the products and discriminant, 25 square-root stages (one root bit each),
// one set-up stage, 34 divider stages (one quotient bit each), one clamp stage and the output
// register. The stages up to the clamp stage advance together; a skid register behind the output
// register keeps the input open while a result waits, and the input closes only when it is full.
module quadratic_real_root_solver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrs_coef_if.sink   coef_i,
  qrs_root_if.source root_o
);
  import qrs_pkg::*;

  logic en;

  // Front end.
  logic                fr_v;
  logic [RAD_BITS-1:0] fr_rad;
  sq_side_t            fr_side;

  // Square root.
  logic                sq_v;
  logic [SQ_BITS-1:0]  sq_root;
  sq_side_t            sq_side;

  // Numerator set-up stage.
  logic                pp_v_q;
  logic [NUM_BITS-1:0] pp_num_q [LANES];
  logic [DEN_BITS-1:0] pp_den_q [LANES];
  dv_side_t            pp_side_q;
  logic [NUM_BITS-1:0] pp_num_d [LANES];
  logic [DEN_BITS-1:0] pp_den_d [LANES];
  dv_side_t            pp_side_d;

  // Divider.
  logic                dv_v;
  logic [QUO_BITS-1:0] dv_quo [LANES];
  dv_side_t            dv_side;

  // Clamp stage and output buffering.
  logic fn_v_q;
  res_t fn_q, fn_d;
  logic out_v_q, skid_v_q, push, out_free;
  res_t out_q, skid_q;

  // Signed quotient clamped to Q16.16; the top bit is the saturation flag.
  function automatic logic [ROOT_BITS:0] clamp_q(input logic [QUO_BITS-1:0] q, input logic neg);
    logic [QUO_BITS-1:0] lim;
    logic [QUO_BITS-1:0] nq;
    lim = QUO_BITS'(1) << (ROOT_BITS - 1);
    nq  = -q;
    if (neg) begin
      if (q > lim) begin
        clamp_q = {1'b1, 1'b1, {(ROOT_BITS-1){1'b0}}};
      end else begin
        clamp_q = {1'b0, nq[ROOT_BITS-1:0]};
      end
    end else begin
      if (q >= lim) begin
        clamp_q = {1'b1, 1'b0, {(ROOT_BITS-1){1'b1}}};
      end else begin
        clamp_q = {1'b0, q[ROOT_BITS-1:0]};
      end
    end
  endfunction

  // The whole pipeline moves while the skid register is empty.
  assign en           = !skid_v_q;
  assign coef_i.ready = en;

  qrs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (coef_i.valid),
    .a_i     (coef_i.coef_a),
    .b_i     (coef_i.coef_b),
    .c_i     (coef_i.coef_c),
    .valid_o (fr_v),
    .rad_o   (fr_rad),
    .side_o  (fr_side)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Numerators and divisors as magnitudes with the quotient signs alongside.
  always_comb begin
    logic signed [SUM_BITS-1:0] nbx, sx, sum1, sum2;
    logic [SUM_BITS-1:0]        m1, m2;
    logic [COEF_BITS-1:0]       ua, ub, uc;
    logic                       a_neg, b_neg, c_pos;
    nbx   = SUM_BITS'(sq_side.nb);
    sx    = SUM_BITS'(sq_root);
    sum1  = nbx + sx;
    sum2  = nbx - sx;
    m1    = sum1[SUM_BITS-1] ? SUM_BITS'(-sum1) : SUM_BITS'(sum1);
    m2    = sum2[SUM_BITS-1] ? SUM_BITS'(-sum2) : SUM_BITS'(sum2);
    a_neg = sq_side.a[COEF_BITS-1];
    b_neg = sq_side.b[COEF_BITS-1];
    c_pos = !sq_side.c[COEF_BITS-1] && (sq_side.c != '0);
    ua    = a_neg ? COEF_BITS'(-sq_side.a) : COEF_BITS'(sq_side.a);
    ub    = b_neg ? COEF_BITS'(-sq_side.b) : COEF_BITS'(sq_side.b);
    uc    = sq_side.c[COEF_BITS-1] ? COEF_BITS'(-sq_side.c) : COEF_BITS'(sq_side.c);

    pp_side_d.kind = sq_side.kind;
    pp_num_d[1]    = {m2[SUM_BITS-2:0], {FRAC_BITS{1'b0}}};
    pp_den_d[1]    = {ua, 1'b0};
    pp_side_d.neg2 = sum2[SUM_BITS-1] ^ a_neg;
    if (sq_side.kind == KIND_LINEAR) begin
      // Linear root: -c * 2^16 / b.
      pp_num_d[0]    = NUM_BITS'({uc, {(2*FRAC_BITS){1'b0}}});
      pp_den_d[0]    = {1'b0, ub};
      pp_side_d.neg1 = c_pos ^ b_neg;
    end else begin
      pp_num_d[0]    = {m1[SUM_BITS-2:0], {FRAC_BITS{1'b0}}};
      pp_den_d[0]    = {ua, 1'b0};
      pp_side_d.neg1 = sum1[SUM_BITS-1] ^ a_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q <= 1'b0;
    end else if (en) begin
      pp_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_num_q  <= pp_num_d;
      pp_den_q  <= pp_den_d;
      pp_side_q <= pp_side_d;
    end
  end

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pp_v_q),
    .num_i   (pp_num_q),
    .den_i   (pp_den_q),
    .side_i  (pp_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // Signs, clamping and zeroing of roots that the kind does not use.
  always_comb begin
    logic [ROOT_BITS:0] c1, c2;
    c1      = clamp_q(dv_quo[0], dv_side.neg1);
    c2      = clamp_q(dv_quo[1], dv_side.neg2);
    fn_d.kind = dv_side.kind;
    case (dv_side.kind) inside
      KIND_LINEAR: begin
        fn_d.r1  = c1[ROOT_BITS-1:0];
        fn_d.r2  = '0;
        fn_d.sat = c1[ROOT_BITS];
      end
      KIND_DOUBLE, KIND_TWO: begin
        fn_d.r1  = c1[ROOT_BITS-1:0];
        fn_d.r2  = c2[ROOT_BITS-1:0];
        fn_d.sat = c1[ROOT_BITS] | c2[ROOT_BITS];
      end
      default: begin
        fn_d.r1  = '0;
        fn_d.r2  = '0;
        fn_d.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_v_q <= 1'b0;
    end else if (en) begin
      fn_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fn_q <= fn_d;
    end
  end

  // Output register with a skid register behind it.
  assign push     = en && fn_v_q;
  assign out_free = !out_v_q || root_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : fn_q;
    end else if (push) begin
      skid_q <= fn_q;
    end
  end

  assign root_o.valid     = out_v_q;
  assign root_o.root_kind = out_q.kind;
  assign root_o.root_one  = out_q.r1;
  assign root_o.root_two  = out_q.r2;
  assign root_o.saturated = out_q.sat;

  // The skid register only holds a result while the output register is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid register full while output register is empty");

  // A stalled output closes the input only once the skid register has filled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_v_q && !root_o.ready && !push && !skid_v_q) |=> coef_i.ready)
    else $error("input closed without a filled skid register");

  // Equations without real roots report zero roots and no saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_v_q && (out_q.kind == KIND_NOT_EQ || out_q.kind == KIND_NO_ROOT))
                   |-> (out_q.r1 == '0 && out_q.r2 == '0 && !out_q.sat))
    else $error("nonzero root reported without a real root");

  // A double root reports the same value twice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_v_q && out_q.kind == KIND_DOUBLE) |-> (out_q.r1 == out_q.r2))
    else $error("double root with differing values");

endmodule
